// ===== rtl/jxsl_pkg.sv =====
`default_nettype none

package jxsl_pkg;

  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_SOI    = 8'hD8;
  localparam logic [7:0] MARK_APP1   = 8'hE1;
  localparam logic [7:0] MARK_SOS    = 8'hDA;

  localparam int LEN_BITS    = 27;
  localparam int SEG_BITS    = 16;
  localparam int SIG_LEN     = 28;
  localparam int PACKET_LEAD = 29;

  // Namespace header bytes, in stream order.
  function automatic logic [7:0] sig_byte(input logic [4:0] idx);
    logic [7:0] b;
    unique case (idx)
      5'd0:  b = 8'h68;
      5'd1:  b = 8'h74;
      5'd2:  b = 8'h74;
      5'd3:  b = 8'h70;
      5'd4:  b = 8'h3A;
      5'd5:  b = 8'h2F;
      5'd6:  b = 8'h2F;
      5'd7:  b = 8'h6E;
      5'd8:  b = 8'h73;
      5'd9:  b = 8'h2E;
      5'd10: b = 8'h61;
      5'd11: b = 8'h64;
      5'd12: b = 8'h6F;
      5'd13: b = 8'h62;
      5'd14: b = 8'h65;
      5'd15: b = 8'h2E;
      5'd16: b = 8'h63;
      5'd17: b = 8'h6F;
      5'd18: b = 8'h6D;
      5'd19: b = 8'h2F;
      5'd20: b = 8'h78;
      5'd21: b = 8'h61;
      5'd22: b = 8'h70;
      5'd23: b = 8'h2F;
      5'd24: b = 8'h31;
      5'd25: b = 8'h2E;
      5'd26: b = 8'h30;
      5'd27: b = 8'h2F;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/jpeg_xmp_segment_locator.sv =====
// JPEG XMP segment locator.
// Input channel: one file byte per word (byte_value), with the file's total
// byte count (data_length, same on every word of a file) and last_byte on the
// final word. in_valid/in_stall: a word moves when in_valid is high and
// in_stall is low.
// Output channel: at most one result word per file (found, xmp_offset,
// xmp_length), handed over when out_valid is high and out_stall is low.
// Not-found results carry zero offset and length.
// A result passes through the input register and then the result register
// before it appears on the output. Throughput: one word per cycle while the
// receiver takes results; a stall with a result waiting holds the input. The
// parse state updates in a single pass per word.
// Once a file is decided, its remaining bytes are consumed and dropped until
// last_byte, which always returns the parser to its start state.
// Reset (rst, synchronous) empties both registers and restarts the parser.
// When the receiver stalls with a result waiting, the input register holds
// its word and in_stall rises; nothing is lost or repeated.
`default_nettype none

module jpeg_xmp_segment_locator #(
  parameter int POSITION_BITS = 27
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  byte_value,
  input  wire logic [26:0] data_length,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             found,
  output logic [26:0]      xmp_offset,
  output logic [15:0]      xmp_length
);

  localparam int PB = POSITION_BITS;
  localparam int CW = ((PB > jxsl_pkg::LEN_BITS) ? PB : jxsl_pkg::LEN_BITS) + 2;

  typedef enum logic [2:0] {
    PH_START0, PH_START1, PH_SCAN, PH_MARKER,
    PH_LENHI, PH_LENLO, PH_SKIP, PH_DONE
  } phase_t;

  // Input register.
  logic        in_full;
  logic [7:0]  r_byte;
  logic [26:0] r_len;
  logic        r_last;

  // Parse state.
  phase_t          phase, phase_next;
  logic [PB-1:0]   byte_position, byte_position_next;
  logic [PB-1:0]   marker_position, marker_position_next;
  logic [7:0]      marker_code, marker_code_next;
  logic [15:0]     segment_length, segment_length_next;
  logic [4:0]      header_index, header_index_next;
  logic            header_matches, header_matches_next;
  logic [15:0]     skip_remaining, skip_remaining_next;

  logic        emit, hit;
  logic [26:0] res_off;
  logic [15:0] res_len;

  logic go;

  // Advance the input word whenever the result register can take a word.
  assign go       = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !go;

  logic [CW-1:0] pos_x, mpos_x, len_x, seg_x, off_x;
  logic [15:0]   seg_new;
  logic          check;
  logic [15:0]   skip_dec;

  always_comb begin
    pos_x    = CW'(byte_position);
    mpos_x   = CW'(marker_position);
    len_x    = CW'(r_len);
    seg_new  = {segment_length[15:8], r_byte};
    seg_x    = CW'(seg_new);
    off_x    = mpos_x + CW'(4 + jxsl_pkg::PACKET_LEAD);
    check    = (marker_code == jxsl_pkg::MARK_APP1) &&
               (off_x < len_x) &&
               (seg_new >= 16'(2 + jxsl_pkg::PACKET_LEAD)) &&
               (mpos_x + CW'(2) + seg_x <= len_x);
    skip_dec = skip_remaining - 16'd1;

    phase_next           = phase;
    byte_position_next   = byte_position + PB'(1);
    marker_position_next = marker_position;
    marker_code_next     = marker_code;
    segment_length_next  = segment_length;
    header_index_next    = header_index;
    header_matches_next  = header_matches;
    skip_remaining_next  = skip_remaining;
    emit    = 1'b0;
    hit     = 1'b0;
    res_off = '0;
    res_len = '0;

    unique case (phase)
      PH_START0: begin
        if (r_len < 27'd4 || r_byte != jxsl_pkg::MARK_PREFIX) begin
          emit       = 1'b1;
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_START1;
        end
      end
      PH_START1: begin
        if (r_byte != jxsl_pkg::MARK_SOI) begin
          emit       = 1'b1;
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_SCAN;
        end
      end
      PH_SCAN: begin
        if (pos_x + CW'(4) >= len_x) begin
          emit       = 1'b1;
          phase_next = PH_DONE;
        end else if (r_byte == jxsl_pkg::MARK_PREFIX) begin
          marker_position_next = byte_position;
          phase_next           = PH_MARKER;
        end
      end
      PH_MARKER: begin
        if (r_byte == jxsl_pkg::MARK_PREFIX) begin
          // Fill byte: restart the marker here unless the data runs out.
          if (pos_x + CW'(4) >= len_x) begin
            emit       = 1'b1;
            phase_next = PH_DONE;
          end else begin
            marker_position_next = byte_position;
          end
        end else begin
          marker_code_next = r_byte;
          phase_next       = PH_LENHI;
        end
      end
      PH_LENHI: begin
        segment_length_next = {r_byte, 8'h00};
        phase_next          = PH_LENLO;
      end
      PH_LENLO: begin
        segment_length_next = seg_new;
        if (!check && marker_code == jxsl_pkg::MARK_SOS) begin
          emit       = 1'b1;
          phase_next = PH_DONE;
        end else begin
          header_matches_next = check;
          header_index_next   = '0;
          skip_remaining_next = (seg_new < 16'd2) ? 16'd0 : seg_new - 16'd2;
          phase_next = (seg_new > 16'd2) ? PH_SKIP : PH_SCAN;
        end
      end
      PH_SKIP: begin
        if (header_matches && header_index < 5'(jxsl_pkg::SIG_LEN) &&
            r_byte == jxsl_pkg::sig_byte(header_index) &&
            header_index == 5'(jxsl_pkg::SIG_LEN - 1)) begin
          // Whole namespace header matched: report the packet.
          header_index_next = header_index + 5'd1;
          emit       = 1'b1;
          hit        = 1'b1;
          res_off    = off_x[26:0];
          res_len    = segment_length - 16'(2 + jxsl_pkg::PACKET_LEAD);
          phase_next = PH_DONE;
        end else begin
          if (header_matches && header_index < 5'(jxsl_pkg::SIG_LEN)) begin
            if (r_byte != jxsl_pkg::sig_byte(header_index)) begin
              header_matches_next = 1'b0;
            end else begin
              header_index_next = header_index + 5'd1;
            end
          end
          skip_remaining_next = skip_dec;
          if (skip_dec == 16'd0) begin
            phase_next = PH_SCAN;
          end
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (r_last) begin
      // End of file: report not-found if still undecided, then restart.
      if (!emit && phase != PH_DONE) begin
        emit = 1'b1;
      end
      phase_next           = PH_START0;
      byte_position_next   = '0;
      marker_position_next = '0;
      marker_code_next     = '0;
      segment_length_next  = '0;
      header_index_next    = '0;
      header_matches_next  = 1'b1;
      skip_remaining_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full         <= 1'b0;
      out_valid       <= 1'b0;
      phase           <= PH_START0;
      byte_position   <= '0;
      marker_position <= '0;
      marker_code     <= '0;
      segment_length  <= '0;
      header_index    <= '0;
      header_matches  <= 1'b1;
      skip_remaining  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        in_full <= 1'b1;
        r_byte  <= byte_value;
        r_len   <= data_length;
        r_last  <= last_byte;
      end else if (go) begin
        in_full <= 1'b0;
      end

      if (go) begin
        phase           <= phase_next;
        byte_position   <= byte_position_next;
        marker_position <= marker_position_next;
        marker_code     <= marker_code_next;
        segment_length  <= segment_length_next;
        header_index    <= header_index_next;
        header_matches  <= header_matches_next;
        skip_remaining  <= skip_remaining_next;
      end

      if (go && emit) begin
        out_valid  <= 1'b1;
        found      <= hit;
        xmp_offset <= res_off;
        xmp_length <= res_len;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
module tb_top;

  // Marker codes used by the stimulus beyond the ones the package defines.
  localparam logic [7:0] MARK_SOF0 = 8'hC0;
  localparam logic [7:0] MARK_DHT  = 8'hC4;
  localparam logic [7:0] MARK_EOI  = 8'hD9;
  localparam logic [7:0] MARK_DQT  = 8'hDB;
  localparam logic [7:0] MARK_APP0 = 8'hE0;

  localparam int unsigned MAX_LEN = 104857600;
  localparam int CYCLE_LIMIT = 400000;

  // XMP namespace header, first byte in the top bits.
  localparam logic [8*28-1:0] NS_HDR =
    224'h687474703A2F2F6E732E61646F62652E636F6D2F7861702F312E302F;

  typedef enum logic [2:0] {
    ST_SOI_FF, ST_SOI_D8, ST_SCAN, ST_MARKER, ST_LEN_HI, ST_LEN_LO, ST_SKIP, ST_DONE
  } locator_phase_t;

  typedef struct packed {
    logic        hit;
    logic [26:0] offset;
    logic [15:0] len_bytes;
  } xmp_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  byte_value = 8'h00;
  logic [26:0] data_length = 27'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        found;
  logic [26:0] xmp_offset;
  logic [15:0] xmp_length;

  // Locator state as the testbench tracks it.
  locator_phase_t loc_phase;
  logic [26:0]    loc_pos;
  logic [26:0]    loc_mark;
  logic [7:0]     loc_code;
  logic [15:0]    loc_seg;
  int             loc_hdr_idx;
  bit             loc_hdr_ok;
  logic [15:0]    loc_skip;
  bit             loc_decided;

  xmp_result_t xmp_expected[$];
  logic [7:0]  file_buf[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int sent_items = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  jpeg_xmp_segment_locator uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_value (byte_value),
    .data_length(data_length),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .xmp_offset (xmp_offset),
    .xmp_length (xmp_length)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Append one byte to the file being built.
  task automatic add_byte(input logic [7:0] v);
    file_buf.insert(file_buf.size(), v);
  endtask

  task automatic reset_locator_state();
    loc_phase   = ST_SOI_FF;
    loc_pos     = '0;
    loc_mark    = '0;
    loc_code    = '0;
    loc_seg     = '0;
    loc_hdr_idx = 0;
    loc_hdr_ok  = 1'b1;
    loc_skip    = '0;
    loc_decided = 1'b0;
  endtask

  // Queue the one result of the current file and stop parsing it.
  task automatic expect_xmp(input logic hit, input logic [26:0] offset,
                            input logic [15:0] len_bytes);
    xmp_result_t want;
    want.hit       = hit;
    want.offset    = offset;
    want.len_bytes = len_bytes;
    xmp_expected.insert(xmp_expected.size(), want);
    loc_decided = 1'b1;
    loc_phase   = ST_DONE;
  endtask

  // Advance the parser by one accepted word and queue any result it decides.
  task automatic predict_xmp_word(input logic [7:0] b, input logic [26:0] len,
                                  input logic lst);
    int unsigned pos, mark, seg;
    bit emitted, check;
    pos     = 32'(loc_pos);
    mark    = 32'(loc_mark);
    emitted = 1'b0;
    sent_items++;
    case (loc_phase)
      ST_SOI_FF: begin
        if (len < 4 || b != jxsl_pkg::MARK_PREFIX) begin
          expect_xmp(1'b0, '0, '0);
          emitted = 1'b1;
        end else loc_phase = ST_SOI_D8;
      end
      ST_SOI_D8: begin
        if (b != jxsl_pkg::MARK_SOI) begin
          expect_xmp(1'b0, '0, '0);
          emitted = 1'b1;
        end else loc_phase = ST_SCAN;
      end
      ST_SCAN: begin
        if (pos + 4 >= len) begin
          expect_xmp(1'b0, '0, '0);
          emitted = 1'b1;
        end else if (b == jxsl_pkg::MARK_PREFIX) begin
          loc_mark  = loc_pos;
          loc_phase = ST_MARKER;
        end
      end
      ST_MARKER: begin
        if (b == jxsl_pkg::MARK_PREFIX) begin
          // fill byte: the marker moves up unless the data runs out
          if (pos + 4 >= len) begin
            expect_xmp(1'b0, '0, '0);
            emitted = 1'b1;
          end else loc_mark = loc_pos;
        end else begin
          loc_code  = b;
          loc_phase = ST_LEN_HI;
        end
      end
      ST_LEN_HI: begin
        loc_seg   = {b, 8'h00};
        loc_phase = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        loc_seg = {loc_seg[15:8], b};
        seg     = 32'(loc_seg);
        check   = loc_code == jxsl_pkg::MARK_APP1 &&
                  mark + 4 + jxsl_pkg::PACKET_LEAD < len &&
                  seg >= 2 + jxsl_pkg::PACKET_LEAD && mark + 2 + seg <= len;
        if (!check && loc_code == jxsl_pkg::MARK_SOS) begin
          expect_xmp(1'b0, '0, '0);
          emitted = 1'b1;
        end else begin
          loc_hdr_ok  = check;
          loc_hdr_idx = 0;
          loc_skip    = (seg < 2) ? 16'd0 : 16'(seg - 2);
          loc_phase   = (loc_skip != 0) ? ST_SKIP : ST_SCAN;
        end
      end
      ST_SKIP: begin
        if (loc_hdr_ok && loc_hdr_idx < jxsl_pkg::SIG_LEN) begin
          if (b != NS_HDR[8*(jxsl_pkg::SIG_LEN-1-loc_hdr_idx) +: 8]) loc_hdr_ok = 1'b0;
          else begin
            loc_hdr_idx++;
            if (loc_hdr_idx == jxsl_pkg::SIG_LEN) begin
              expect_xmp(1'b1, 27'(mark + 4 + jxsl_pkg::PACKET_LEAD),
                         16'(loc_seg - 2 - jxsl_pkg::PACKET_LEAD));
              emitted = 1'b1;
            end
          end
        end
        if (!emitted) begin
          loc_skip = loc_skip - 16'd1;
          if (loc_skip == 0) loc_phase = ST_SCAN;
        end
      end
      default: ;
    endcase
    loc_pos = loc_pos + 27'd1;
    if (lst) begin
      // an undecided file reports not-found on its last byte
      if (!emitted && !loc_decided) expect_xmp(1'b0, '0, '0);
      reset_locator_state();
    end
  endtask

  // Offer one word, idling first at random; hold it until accepted.
  task automatic send_word(input logic [7:0] b, input logic [26:0] len, input logic lst);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    byte_value  <= b;
    data_length <= len;
    last_byte   <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_xmp_word(b, len, lst);
  endtask

  task automatic send_file_buf(input logic [26:0] len);
    foreach (file_buf[i]) send_word(file_buf[i], len, i == file_buf.size() - 1);
  endtask

  // Drop valid and hold the sender until every queued result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (xmp_expected.size() != 0);
  endtask

  // Check each result word against the oldest queued expectation; stall at random.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (xmp_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result found=%0b offset=%0d length=%0d",
                                  found, xmp_offset, xmp_length));
      end else begin
        xmp_result_t want;
        want = xmp_expected.pop_front();
        if (found !== want.hit)
          report_mismatch($sformatf("found got %0b want %0b", found, want.hit));
        if (xmp_offset !== want.offset)
          report_mismatch($sformatf("xmp_offset got %0d want %0d", xmp_offset, want.offset));
        if (xmp_length !== want.len_bytes)
          report_mismatch($sformatf("xmp_length got %0d want %0d",
                                    xmp_length, want.len_bytes));
      end
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Short files that each hit one not-found path.
  task automatic test_directed();
    file_buf = {jxsl_pkg::MARK_PREFIX};                 // data too short
    send_file_buf(27'd3);
    file_buf = {8'h00};                                 // bad first start byte
    send_file_buf(27'(MAX_LEN));
    file_buf = {jxsl_pkg::MARK_PREFIX, 8'h00};          // bad second start byte
    send_file_buf(27'(MAX_LEN));
    // data ends right after start
    file_buf = {jxsl_pkg::MARK_PREFIX, jxsl_pkg::MARK_SOI, 8'hFF};
    send_file_buf(27'd4);
    // length 1 acts like 2, then the file ends with nothing decided
    file_buf = {jxsl_pkg::MARK_PREFIX, jxsl_pkg::MARK_SOI, jxsl_pkg::MARK_PREFIX,
                MARK_DHT, 8'h00, 8'h01, jxsl_pkg::MARK_PREFIX, MARK_EOI};
    send_file_buf(27'd100);
    file_buf = {jxsl_pkg::MARK_PREFIX, jxsl_pkg::MARK_SOI, jxsl_pkg::MARK_PREFIX,
                jxsl_pkg::MARK_SOS, 8'h00, 8'h0C};
    send_file_buf(27'd100);
  endtask

  // JPEG-like file: a few segments with random lengths, then an XMP APP1, a scan or junk.
  task automatic send_jpeg_file();
    int seglen, mark_at, bad_at, ending, bound, i;
    logic [7:0] val;
    logic [26:0] len;
    file_buf = {jxsl_pkg::MARK_PREFIX, jxsl_pkg::MARK_SOI};
    mark_at  = -1;
    seglen   = 0;
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 254)));
      repeat ($urandom_range(1, 3)) add_byte(jxsl_pkg::MARK_PREFIX);
      case ($urandom_range(0, 3))
        0: val = jxsl_pkg::MARK_APP1;
        1: val = MARK_APP0;
        2: val = MARK_DQT;
        default: val = 8'($urandom_range(0, 254));
      endcase
      if (val == jxsl_pkg::MARK_SOS) val = MARK_SOF0;
      add_byte(val);
      seglen = $urandom_range(0, 40);
      add_byte(8'(seglen >> 8));
      add_byte(8'(seglen));
      repeat (seglen - 2) add_byte(8'($urandom));
    end
    ending = $urandom_range(0, 9);
    if (ending < 6) begin
      repeat ($urandom_range(1, 2)) add_byte(jxsl_pkg::MARK_PREFIX);
      mark_at = file_buf.size() - 1;
      add_byte(jxsl_pkg::MARK_APP1);
      case ($urandom_range(0, 9))
        0: seglen = 65535;
        1: seglen = $urandom_range(31, 65535);
        2: seglen = $urandom_range(29, 31);
        default: seglen = $urandom_range(31, 70);
      endcase
      add_byte(8'(seglen >> 8));
      add_byte(8'(seglen));
      bad_at = ($urandom_range(0, 4) == 0) ?
               int'($urandom_range(0, jxsl_pkg::SIG_LEN - 1)) : -1;
      for (i = 0; i < jxsl_pkg::SIG_LEN; i++) begin
        val = NS_HDR[8*(jxsl_pkg::SIG_LEN-1-i) +: 8];
        if (i == bad_at) val = val ^ 8'($urandom_range(1, 255));
        add_byte(val);
      end
      repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
    end else if (ending < 8) begin
      add_byte(jxsl_pkg::MARK_PREFIX);
      add_byte(jxsl_pkg::MARK_SOS);
      add_byte(8'h00);
      add_byte(8'($urandom_range(0, 20)));
      repeat ($urandom_range(0, 4)) add_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
      add_byte(jxsl_pkg::MARK_PREFIX);
      add_byte(MARK_EOI);
    end
    // Pick data_length around the packet's bounds check most of the time.
    bound = mark_at + 2 + seglen;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        if (mark_at >= 0)
          len = 27'(bound + int'($urandom_range(0, 2)) - int'($urandom_range(0, 3) == 0));
        else len = 27'(file_buf.size());
      end
      6, 7: len = 27'(file_buf.size());
      8: len = 27'($urandom_range(0, MAX_LEN));
      default: len = 27'(MAX_LEN);
    endcase
    send_file_buf(len);
  endtask

  // Short random byte runs, some with a valid start, ending anywhere.
  task automatic send_noise_file();
    int n;
    logic [26:0] len;
    file_buf = {};
    n = $urandom_range(1, 24);
    if ($urandom_range(0, 1) == 1) file_buf = {jxsl_pkg::MARK_PREFIX, jxsl_pkg::MARK_SOI};
    while (file_buf.size() < n)
      add_byte(($urandom_range(0, 3) == 0) ? jxsl_pkg::MARK_PREFIX : 8'($urandom));
    case ($urandom_range(0, 2))
      0: len = 27'($urandom_range(0, 7));
      1: len = 27'(n);
      default: len = 27'($urandom_range(0, MAX_LEN));
    endcase
    send_file_buf(len);
  endtask

  task automatic test_random_files(input int item_goal, input int file_goal);
    int sent_start, files;
    sent_start = sent_items;
    files      = 0;
    while (sent_items - sent_start < item_goal || files < file_goal) begin
      if ($urandom_range(0, 99) < 15) send_noise_file();
      else send_jpeg_file();
      files++;
    end
  endtask

  initial begin
    reset_locator_state();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Sender idles often, receiver stalls most of the time.
    idle_pct  = 38;
    stall_pct = 82;
    test_directed();
    test_random_files(450, 5);
    wait_drained();

    // Swap the pressure.
    idle_pct  = 82;
    stall_pct = 38;
    test_random_files(450, 5);
    wait_drained();

    // Full rate on both sides.
    idle_pct  = 0;
    stall_pct = 0;
    test_random_files(450, 5);
    wait_drained();
    repeat (8) @(posedge clk);

    if (mismatch_count == 0 && xmp_expected.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
